FILE: rtl/core/linear_byte_buffer_with_compaction_defines.svh
// Assertion macros shared by the byte buffer RTL.
`ifndef LINEAR_BYTE_BUFFER_WITH_COMPACTION_DEFINES_SVH
`define LINEAR_BYTE_BUFFER_WITH_COMPACTION_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define LBBC_ASSERT_HOLDS(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// A condition that implies another in the same cycle.
`define LBBC_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// A condition that implies another in the following cycle.
`define LBBC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/lbbc_pkg.sv
// Shared types and constants of the linear byte buffer.
package lbbc_pkg;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int CNT_W  = 9;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPACT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET   = 2'd3;

    // Capacity register value after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    // Result fields known when a transaction is accepted; the byte follows later.
    typedef struct packed {
        logic             rvalid;
        logic             waccept;
        logic [CNT_W-1:0] unread;
        logic [CNT_W-1:0] free;
    } res_meta_t;

endpackage

FILE: rtl/core/lbbc_ifs.sv
// Handshake interfaces for the request, response and configuration channels.
interface lbbc_req_if;
    import lbbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] write_byte;
    modport source (output valid, mode, write_byte, input ready);
    modport sink   (input valid, mode, write_byte, output ready);
endinterface

interface lbbc_rsp_if;
    import lbbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              write_accepted;
    logic [CNT_W-1:0]  unread_count;
    logic [CNT_W-1:0]  free_space;
    modport source (output valid, read_byte, read_valid, write_accepted, unread_count,
                    free_space, input ready);
    modport sink   (input valid, read_byte, read_valid, write_accepted, unread_count,
                    free_space, output ready);
endinterface

interface lbbc_cfg_if;
    import lbbc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] capacity_in_use;
    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

FILE: rtl/core/linear_byte_buffer_with_compaction.sv
// Linear byte buffer with read and write positions and compaction.
// Write, read, reset and trivial compact transactions: one per cycle while the result stage
// has room; results pass the pending slot and output register. A compaction that moves n
// unread bytes holds off requests: one store read and one store write per cycle over the
// single synchronous byte store, each write in the cycle after its read, then back to idle.
// Reset clears both positions and sets the capacity to 256; the store is not cleared.
`include "linear_byte_buffer_with_compaction_defines.svh"

module linear_byte_buffer_with_compaction #(
    parameter int STORE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    lbbc_cfg_if.sink    cfg,
    lbbc_req_if.sink    req,
    lbbc_rsp_if.source  rsp
);
    import lbbc_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] DEPTH_CAP =
        CNT_W'((STORE_DEPTH > POS_MAX) ? POS_MAX : STORE_DEPTH);

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_COMPACT = 1'b1;

    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] rp_reg;
    logic [CNT_W-1:0] rp_next;
    logic [CNT_W-1:0] wp_reg;
    logic [CNT_W-1:0] wp_next;
    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] cp_src_reg;
    logic [CNT_W-1:0] cp_src_next;
    logic [CNT_W-1:0] cp_dst_reg;
    logic [CNT_W-1:0] cp_dst_next;
    logic [CNT_W-1:0] cp_rem_reg;
    logic [CNT_W-1:0] cp_rem_next;
    logic             cp_rd_reg;
    logic             cp_rd_next;

    logic [CNT_W-1:0]  cap_eff;
    logic              accept;
    logic              room;
    logic              push;
    res_meta_t         meta;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // Configuration register; writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.capacity_in_use;
        end
    end

    // Effective capacity never exceeds the store.
    assign cap_eff = (cap_reg > DEPTH_CAP) ? DEPTH_CAP : cap_reg;

    assign req.ready = (state_reg == ST_IDLE) && room;
    assign accept    = req.valid && req.ready;

    // Position update, store access and the compaction walk.
    always_comb
    begin
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        state_next  = state_reg;
        cp_src_next = cp_src_reg;
        cp_dst_next = cp_dst_reg;
        cp_rem_next = cp_rem_reg;
        cp_rd_next  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        push        = 1'b0;
        meta        = '0;

        if (state_reg == ST_COMPACT)
        begin
            // Read one unread byte per cycle and write the previous one down.
            if (cp_rem_reg != '0)
            begin
                mem_re      = 1'b1;
                mem_raddr   = AW'(cp_src_reg);
                cp_src_next = cp_src_reg + CNT_W'(1);
                cp_rem_next = cp_rem_reg - CNT_W'(1);
                cp_rd_next  = 1'b1;
            end
            if (cp_rd_reg)
            begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(cp_dst_reg);
                mem_wdata   = rdata_reg;
                cp_dst_next = cp_dst_reg + CNT_W'(1);
            end
            if ((cp_rem_reg == '0) && !cp_rd_reg)
            begin
                state_next = ST_IDLE;
            end
        end
        else if (accept)
        begin
            push = 1'b1;
            case (req.mode)
                MODE_WRITE:
                begin
                    if (wp_reg < cap_eff)
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = AW'(wp_reg);
                        mem_wdata    = req.write_byte;
                        wp_next      = wp_reg + CNT_W'(1);
                        meta.waccept = 1'b1;
                    end
                end
                MODE_READ:
                begin
                    if (rp_reg < wp_reg)
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = AW'(rp_reg);
                        meta.rvalid = 1'b1;
                        if ((rp_reg + CNT_W'(1)) == wp_reg)
                        begin
                            rp_next = '0;
                            wp_next = '0;
                        end
                        else
                        begin
                            rp_next = rp_reg + CNT_W'(1);
                        end
                    end
                end
                MODE_COMPACT:
                begin
                    if (rp_reg != '0)
                    begin
                        rp_next = '0;
                        if (rp_reg >= wp_reg)
                        begin
                            wp_next = '0;
                        end
                        else
                        begin
                            // Positions take their final values now; the walk follows.
                            wp_next     = wp_reg - rp_reg;
                            state_next  = ST_COMPACT;
                            cp_src_next = rp_reg;
                            cp_dst_next = '0;
                            cp_rem_next = wp_reg - rp_reg;
                        end
                    end
                end
                default:
                begin
                    rp_next = '0;
                    wp_next = '0;
                end
            endcase
            meta.unread = wp_next - rp_next;
            meta.free   = (cap_eff > wp_next) ? (cap_eff - wp_next) : '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            state_reg  <= ST_IDLE;
            cp_src_reg <= '0;
            cp_dst_reg <= '0;
            cp_rem_reg <= '0;
            cp_rd_reg  <= 1'b0;
        end
        else
        begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            state_reg  <= state_next;
            cp_src_reg <= cp_src_next;
            cp_dst_reg <= cp_dst_next;
            cp_rem_reg <= cp_rem_next;
            cp_rd_reg  <= cp_rd_next;
        end
    end

    // Byte store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_raddr];
        end
    end

    lbbc_res_stage u_res_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .meta  (meta),
        .rdata (rdata_reg),
        .room  (room),
        .rsp   (rsp)
    );

    // Checks on the position bookkeeping and the compaction sequencer.
    `LBBC_ASSERT_HOLDS(a_pos_order, clk, rst_n, rp_reg <= wp_reg, "read position passed write position")
    `LBBC_ASSERT_HOLDS(a_wp_bound, clk, rst_n, wp_reg <= DEPTH_CAP, "write position beyond store")
    `LBBC_ASSERT_IMPLIES(a_no_req_compact, clk, rst_n, state_reg == ST_COMPACT, !req.ready, "request taken during compaction")
    `LBBC_ASSERT_NEXT(a_compact_done, clk, rst_n, (state_reg == ST_COMPACT) && (cp_rem_reg == '0) && !cp_rd_reg, state_reg == ST_IDLE, "compaction did not finish")

endmodule

FILE: rtl/core/lbbc_res_stage.sv
// Two-deep result stage: a pending slot that waits for read data and the output register.
module lbbc_res_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  lbbc_pkg::res_meta_t             meta,
    input  logic [lbbc_pkg::BYTE_W-1:0]     rdata,
    output logic                            room,
    lbbc_rsp_if.source                      rsp
);
    import lbbc_pkg::*;

    logic              pend_valid_reg;
    logic              pend_valid_next;
    res_meta_t         pend_meta_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    res_meta_t         out_meta_reg;
    logic              pend_move;

    // The pending entry advances when the output register is empty or being taken.
    assign pend_move = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign room      = !pend_valid_reg || pend_move;

    assign pend_valid_next = push || (pend_valid_reg && !pend_move);
    assign out_valid_next  = pend_move || (out_valid_reg && !rsp.ready);

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload; the read data is sampled as the entry leaves the pending slot.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pend_meta_reg <= meta;
        end
        if (pend_move)
        begin
            out_meta_reg <= pend_meta_reg;
            out_byte_reg <= pend_meta_reg.rvalid ? rdata : '0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_byte      = out_byte_reg;
    assign rsp.read_valid     = out_meta_reg.rvalid;
    assign rsp.write_accepted = out_meta_reg.waccept;
    assign rsp.unread_count   = out_meta_reg.unread;
    assign rsp.free_space     = out_meta_reg.free;

endmodule
